>>> design/sv39ptw_pkg.sv
// shared constants and types for the sv39 page table walker
`default_nettype none

package sv39ptw_pkg;

   localparam int FRAMES      = 64;
   localparam int FRAME_W     = $clog2(FRAMES);
   localparam int NF_W        = $clog2(FRAMES + 1);
   localparam int FRAME_ENT   = 512;
   localparam int VPN_W       = 9;
   localparam int STORE_DEPTH = FRAMES * FRAME_ENT;
   localparam int STORE_AW    = FRAME_W + VPN_W;
   localparam int PPN_W       = 44;
   localparam int PA_W        = 56;
   localparam int VA_W        = 39;
   localparam int PTE_W       = 64;
   // store word: the entry plus a flag for written since its frame was allocated
   localparam int STORE_W     = PTE_W + 1;

   localparam logic [PPN_W-1:0] BASE_PPN_RESET = 44'h000_0008_0000;

   localparam logic [1:0] OP_MAP    = 2'd0;
   localparam logic [1:0] OP_UNMAP  = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOMEM    = 2'd1;
   localparam logic [1:0] ST_UNMAPPED = 2'd2;
   localparam logic [1:0] ST_BADPTR   = 2'd3;

   localparam logic [7:0] PTE_V   = 8'h01;
   localparam logic [7:0] PTE_RWX = 8'h0E;
   localparam logic [7:0] PTE_A   = 8'h40;
   localparam logic [7:0] PTE_D   = 8'h80;

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [STORE_AW-1:0] addr;
   } store_cmd_type;

endpackage

`default_nettype wire

>>> design/sv39_page_table_walker_top.sv
// sv39 page table walker top level: walk sequencer, frame allocator and csr
//
//  channel   ports                                   direction  handshake
//  request   start, busy, req_op, req_virt_addr,     in         start & !busy
//            req_phys_addr, req_perm_bits
//  response  rsp_valid, rsp_status, rsp_page_base    out        one-cycle strobe
//  csr       csr_valid, csr_ready, csr_table_base_ppn in        valid & ready
//
// a walk passes a read state and an evaluate state for each table level it visits;
// a lookup goes down to level 0, while map and unmap leave level 1 for the leaf
// write state. a walk can also end early in an evaluate state; an undefined op
// strobes straight from idle and never raises busy.
// busy drops with the strobe, so a new request waits until the last is answered.
// after reset the store is cleared one entry a cycle, with busy high until done.
`default_nettype none

module sv39_page_table_walker_top (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire [1:0]                     req_op,
   input  wire [sv39ptw_pkg::VA_W-1:0]   req_virt_addr,
   input  wire [sv39ptw_pkg::PA_W-1:0]   req_phys_addr,
   input  wire [7:0]                     req_perm_bits,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [sv39ptw_pkg::PA_W-1:0]  rsp_page_base,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire [sv39ptw_pkg::PPN_W-1:0]  csr_table_base_ppn
);
   import sv39ptw_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_EVAL = 4'b0100,
      S_LEAF = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        op_ff;
   logic [VA_W-1:0]   va_ff;
   logic [PA_W-1:0]   pa_ff;
   logic [7:0]        perm_ff;
   logic [1:0]        level_ff, level_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [NF_W-1:0]   next_free_ff, next_free_in;
   logic [PPN_W-1:0]  base_ppn_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [PA_W-1:0]   rsp_base_ff, rsp_base_in;

   store_cmd_type     cmd;
   logic [STORE_W-1:0] wdata;
   logic [STORE_W-1:0] rd_word;
   logic [PTE_W-1:0]  ent;
   logic              frame_live;
   logic              store_ready;
   logic              accept;

   logic [VPN_W-1:0]  vpn;
   logic [PPN_W-1:0]  ent_ppn;
   logic [PPN_W-1:0]  rel;
   logic              ptr_ok;
   logic [PPN_W-1:0]  new_ppn;

   sv39ptw_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .wdata (wdata),
      .rdata (rd_word),
      .ready (store_ready)
   );

   assign busy      = !store_ready || (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      case (level_ff)
         2'd2:    vpn = va_ff[38:30];
         2'd1:    vpn = va_ff[29:21];
         default: vpn = va_ff[20:12];
      endcase
   end

   // an allocated frame reads zero wherever nothing was written since allocation
   assign frame_live = NF_W'(frame_ff) < next_free_ff;
   assign ent        = (frame_live && !rd_word[PTE_W]) ? '0 : rd_word[PTE_W-1:0];

   assign ent_ppn = ent[53:10];
   assign rel     = ent_ppn - base_ppn_ff;
   assign ptr_ok  = rel < PPN_W'(FRAMES);
   assign new_ppn = base_ppn_ff + PPN_W'(next_free_ff);

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      frame_in      = frame_ff;
      next_free_in  = next_free_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_base_in   = '0;
      cmd.rd_en     = 1'b0;
      cmd.wr_en     = 1'b0;
      cmd.addr      = {frame_ff, vpn};
      wdata         = '0;

      case (state_ff)
         S_IDLE: begin
            level_in = 2'd2;
            frame_in = '0;
            if (accept) begin
               if (req_op inside {OP_MAP, OP_UNMAP, OP_LOOKUP}) begin
                  state_in = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            if (op_ff == OP_LOOKUP) begin
               if (!ent[0]) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_UNMAPPED;
                  state_in      = S_IDLE;
               end else if ((ent[7:0] & PTE_RWX) != 8'h00) begin
                  rsp_valid_in = 1'b1;
                  rsp_base_in  = {ent_ppn, 12'h000};
                  state_in     = S_IDLE;
               end else if (level_ff == 2'd0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_UNMAPPED;
                  state_in      = S_IDLE;
               end else if (!ptr_ok) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_BADPTR;
                  state_in      = S_IDLE;
               end else begin
                  frame_in = rel[FRAME_W-1:0];
                  level_in = level_ff - 2'd1;
                  state_in = S_READ;
               end
            end else if (!ent[0]) begin
               if (op_ff == OP_UNMAP) begin
                  // missing path, nothing to clear
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else if (next_free_ff >= NF_W'(FRAMES)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOMEM;
                  state_in      = S_IDLE;
               end else begin
                  // link a fresh frame; its older entries read as zero from now on,
                  // the link itself counts as written after the allocation
                  cmd.wr_en    = 1'b1;
                  wdata        = {NF_W'(frame_ff) <= next_free_ff, 10'h000, new_ppn,
                                  2'b00, PTE_V};
                  next_free_in = next_free_ff + 1'b1;
                  frame_in     = next_free_ff[FRAME_W-1:0];
                  level_in     = level_ff - 2'd1;
                  state_in     = (level_ff == 2'd1) ? S_LEAF : S_READ;
               end
            end else if (!ptr_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_BADPTR;
               state_in      = S_IDLE;
            end else begin
               frame_in = rel[FRAME_W-1:0];
               level_in = level_ff - 2'd1;
               state_in = (level_ff == 2'd1) ? S_LEAF : S_READ;
            end
         end
         S_LEAF: begin
            cmd.wr_en = 1'b1;
            if (op_ff == OP_MAP) begin
               wdata = {frame_live, 10'h000, pa_ff[55:12], 2'b00,
                        perm_ff | PTE_V | PTE_A | PTE_D};
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= 2'd2;
         frame_ff     <= '0;
         next_free_ff <= NF_W'(1);
         base_ppn_ff  <= BASE_PPN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         frame_ff     <= frame_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            base_ppn_ff <= csr_table_base_ppn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         va_ff   <= req_virt_addr;
         pa_ff   <= req_phys_addr;
         perm_ff <= req_perm_bits;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_page_base = rsp_base_ff;

`ifndef SYNTHESIS
   a_base_zero_unless_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_page_base == '0)
      else $error("page base set on a failed request");

   a_alloc_bounded: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NF_W'(FRAMES) && next_free_ff != '0)
      else $error("frame allocator out of range");

   a_alloc_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> next_free_ff >= $past(next_free_ff))
      else $error("frame allocator went backwards");

   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_op == OP_MAP || req_op == OP_UNMAP || req_op == OP_LOOKUP)
      |=> busy && !rsp_valid)
      else $error("walk request not held busy");

   a_leaf_level: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LEAF |-> level_ff == 2'd0 && op_ff != OP_LOOKUP)
      else $error("leaf write at wrong level");
`endif

endmodule

`default_nettype wire

>>> design/sv39ptw_store.sv
// entry store: single port synchronous memory with a clearing pass after reset
`default_nettype none

module sv39ptw_store (
   input  wire                            clock,
   input  wire                            reset,
   input  sv39ptw_pkg::store_cmd_type     cmd,
   input  wire [sv39ptw_pkg::STORE_W-1:0] wdata,
   output logic [sv39ptw_pkg::STORE_W-1:0] rdata,
   output logic                           ready
);
   import sv39ptw_pkg::*;

   logic [STORE_W-1:0]  mem [STORE_DEPTH];
   logic [STORE_W-1:0]  rdata_ff;
   logic [STORE_AW-1:0] clr_addr_ff, clr_addr_in;
   logic                clearing_ff, clearing_in;

   logic                we;
   logic [STORE_AW-1:0] addr;
   logic [STORE_W-1:0]  wd;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == STORE_AW'(STORE_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clearing_ff <= clearing_in;
      end
   end

   // the clearing pass owns the port until it finishes
   always_comb begin
      if (clearing_ff) begin
         we   = 1'b1;
         addr = clr_addr_ff;
         wd   = '0;
      end else begin
         we   = cmd.wr_en;
         addr = cmd.addr;
         wd   = wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wd;
      end
      if (cmd.rd_en && !clearing_ff) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
   assign ready = !clearing_ff;

endmodule

`default_nettype wire
